### src/srf_pkg.sv
// shared types and constants for the searchable record fifo
// command, status and state encodings, and the controller/datapath interface structs
// no dependencies
`timescale 1ns / 1ps

package srf_pkg;

  localparam int CMD_W            = 3;
  localparam int KEY_W            = 31;
  localparam int POS_W            = 4;
  localparam int STATUS_W         = 3;
  localparam int COUNT_W          = 5;
  localparam int DEPTH_DEF        = 16;
  localparam int PAYLOAD_BITS_DEF = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ      = 3'd0,
    CMD_DEQ      = 3'd1,
    CMD_PEEK     = 3'd2,
    CMD_READ_POS = 3'd3,
    CMD_FIND     = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_RANGE    = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SEARCH,
    S_RESULT
  } state_e;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_POS,
    RD_SCAN
  } rd_sel_e;

  // controller to datapath
  typedef struct packed {
    logic             capture;
    logic             enq;
    logic             pop;
    logic             rd_en;
    rd_sel_e          rd_sel;
    logic             scan_next;
    logic             res_load;
    logic             res_data;
    status_e          res_status;
    logic             out_load;
  } srf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             pos_bad;
    logic             match;
    logic             scan_done;
    logic             out_free;
  } srf_sts_t;

endpackage

### src/searchable_record_fifo_top.sv
// flow from an accepted beat to out_valid_o: enqueue, no-op and every empty, full or out of
// range case go from decode straight to the result; dequeue, peek and read by position add
// a memory read; find reads and compares the held records in turn until a match or the end
// one command at a time: the next beat is taken once the result reaches the output
// register, and the wait grows while a result is stalled there
// reset: rst_ni clears the queue to empty and the output to not valid
`timescale 1ns / 1ps

module searchable_record_fifo_top #(
  parameter int DEPTH        = srf_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = srf_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [srf_pkg::CMD_W-1:0]     command_i,
  input  logic [srf_pkg::KEY_W-1:0]     key_in_i,
  input  logic [PAYLOAD_BITS-1:0]       payload_in_i,
  input  logic [srf_pkg::POS_W-1:0]     position_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [srf_pkg::STATUS_W-1:0]  status_o,
  output logic [srf_pkg::KEY_W-1:0]     key_out_o,
  output logic [PAYLOAD_BITS-1:0]       payload_out_o,
  output logic [srf_pkg::COUNT_W-1:0]   entry_count_o
);

  srf_pkg::srf_cmd_t ctrl_cmd;
  srf_pkg::srf_sts_t dp_sts;

  srf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  srf_dp #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .command_i     (command_i),
    .key_in_i      (key_in_i),
    .payload_in_i  (payload_in_i),
    .position_i    (position_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .key_out_o     (key_out_o),
    .payload_out_o (payload_out_o),
    .entry_count_o (entry_count_o),
    .cmd_i         (ctrl_cmd),
    .sts_o         (dp_sts)
  );

endmodule

### src/srf_ctrl.sv
// controller state machine for the searchable record fifo
// sequences each command through decode, memory read, search and result hand-off; uses srf_pkg
`timescale 1ns / 1ps

module srf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  srf_pkg::srf_sts_t sts_i,
  output srf_pkg::srf_cmd_t cmd_o
);

  srf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srf_pkg::S_IDLE: begin
        if (in_valid_i) state_d = srf_pkg::S_EXEC;
      end
      srf_pkg::S_EXEC: begin
        unique case (sts_i.cmd)
          srf_pkg::CMD_DEQ, srf_pkg::CMD_PEEK: begin
            state_d = sts_i.empty ? srf_pkg::S_RESULT : srf_pkg::S_READ;
          end
          srf_pkg::CMD_READ_POS: begin
            state_d = sts_i.pos_bad ? srf_pkg::S_RESULT : srf_pkg::S_READ;
          end
          srf_pkg::CMD_FIND: begin
            state_d = sts_i.empty ? srf_pkg::S_RESULT : srf_pkg::S_SEARCH;
          end
          default: state_d = srf_pkg::S_RESULT;
        endcase
      end
      srf_pkg::S_READ: state_d = srf_pkg::S_RESULT;
      srf_pkg::S_SEARCH: begin
        if (sts_i.match || sts_i.scan_done) state_d = srf_pkg::S_RESULT;
      end
      srf_pkg::S_RESULT: begin
        if (sts_i.out_free) state_d = srf_pkg::S_IDLE;
      end
      default: state_d = srf_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != srf_pkg::S_IDLE);
    unique case (state_q)
      srf_pkg::S_IDLE: begin
        cmd_o.capture = in_valid_i;
      end
      srf_pkg::S_EXEC: begin
        unique case (sts_i.cmd)
          srf_pkg::CMD_ENQ: begin
            cmd_o.res_load   = 1'b1;
            cmd_o.enq        = !sts_i.full;
            cmd_o.res_status = sts_i.full ? srf_pkg::STAT_FULL : srf_pkg::STAT_OK;
          end
          srf_pkg::CMD_DEQ, srf_pkg::CMD_PEEK: begin
            cmd_o.res_load   = sts_i.empty;
            cmd_o.res_status = srf_pkg::STAT_EMPTY;
            cmd_o.rd_en      = !sts_i.empty;
            cmd_o.rd_sel     = srf_pkg::RD_HEAD;
          end
          srf_pkg::CMD_READ_POS: begin
            cmd_o.res_load   = sts_i.pos_bad;
            cmd_o.res_status = srf_pkg::STAT_RANGE;
            cmd_o.rd_en      = !sts_i.pos_bad;
            cmd_o.rd_sel     = srf_pkg::RD_POS;
          end
          srf_pkg::CMD_FIND: begin
            cmd_o.res_load   = sts_i.empty;
            cmd_o.res_status = srf_pkg::STAT_NOTFOUND;
            cmd_o.rd_en      = !sts_i.empty;
            cmd_o.rd_sel     = srf_pkg::RD_SCAN;
            cmd_o.scan_next  = !sts_i.empty;
          end
          default: begin
            // unused codes: no operation
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = srf_pkg::STAT_OK;
          end
        endcase
      end
      srf_pkg::S_READ: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_data   = 1'b1;
        cmd_o.res_status = srf_pkg::STAT_OK;
        cmd_o.pop        = (sts_i.cmd == srf_pkg::CMD_DEQ);
      end
      srf_pkg::S_SEARCH: begin
        priority if (sts_i.match) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_data   = 1'b1;
          cmd_o.res_status = srf_pkg::STAT_OK;
        end else if (sts_i.scan_done) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = srf_pkg::STAT_NOTFOUND;
        end else begin
          cmd_o.rd_en     = 1'b1;
          cmd_o.rd_sel    = srf_pkg::RD_SCAN;
          cmd_o.scan_next = 1'b1;
        end
      end
      srf_pkg::S_RESULT: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: ;
    endcase
  end

  a_no_enq_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.enq |-> !sts_i.full)
    else $error("record written into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |-> !sts_i.empty)
    else $error("pop from an empty queue");

  a_result_follows_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.res_load && state_q != srf_pkg::S_RESULT) |=> state_q == srf_pkg::S_RESULT)
    else $error("result loaded without moving to hand-off");

endmodule

### src/srf_dp.sv
// datapath for the searchable record fifo: record memory, ring pointers, search
// scan and the output register; driven by srf_ctrl through srf_pkg structs
`timescale 1ns / 1ps

module srf_dp #(
  parameter int DEPTH        = srf_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = srf_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [srf_pkg::CMD_W-1:0]     command_i,
  input  logic [srf_pkg::KEY_W-1:0]     key_in_i,
  input  logic [PAYLOAD_BITS-1:0]       payload_in_i,
  input  logic [srf_pkg::POS_W-1:0]     position_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [srf_pkg::STATUS_W-1:0]  status_o,
  output logic [srf_pkg::KEY_W-1:0]     key_out_o,
  output logic [PAYLOAD_BITS-1:0]       payload_out_o,
  output logic [srf_pkg::COUNT_W-1:0]   entry_count_o,
  input  srf_pkg::srf_cmd_t             cmd_i,
  output srf_pkg::srf_sts_t             sts_o
);

  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int PW     = srf_pkg::POS_W;
  localparam int CMPW   = (CW > PW) ? CW : PW;
  localparam int KW     = srf_pkg::KEY_W;
  localparam int CountW = srf_pkg::COUNT_W;
  localparam logic [AW:0]   DepthA = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);

  // latched command beat
  logic [srf_pkg::CMD_W-1:0] cmd_q;
  logic [KW-1:0]             key_q;
  logic [PAYLOAD_BITS-1:0]   pay_q;
  logic [PW-1:0]             pos_q;

  // ring state
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] scan_q, scan_d;

  // record memory
  logic [KW-1:0]           key_mem [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_mem [DEPTH];
  logic [KW-1:0]           rd_key_q;
  logic [PAYLOAD_BITS-1:0] rd_pay_q;

  // result and output registers
  srf_pkg::status_e        res_status_q;
  logic [KW-1:0]           res_key_q;
  logic [PAYLOAD_BITS-1:0] res_pay_q;
  logic                    out_valid_q;
  logic [srf_pkg::STATUS_W-1:0] out_status_q;
  logic [KW-1:0]           out_key_q;
  logic [PAYLOAD_BITS-1:0] out_pay_q;
  logic [CountW-1:0]       out_count_q;

  logic [CMPW-1:0] pos_ext;
  logic [AW-1:0]   rd_off;
  logic [AW:0]     rd_sum, wr_sum;
  logic [AW-1:0]   rd_slot, wr_slot;

  assign pos_ext = CMPW'(pos_q);

  always_comb begin
    unique case (cmd_i.rd_sel)
      srf_pkg::RD_HEAD: rd_off = '0;
      srf_pkg::RD_POS:  rd_off = pos_ext[AW-1:0];
      srf_pkg::RD_SCAN: rd_off = scan_q[AW-1:0];
      default:          rd_off = '0;
    endcase
  end

  // ring slot = head + offset, wrapped at the depth
  assign rd_sum  = {1'b0, head_q} + {1'b0, rd_off};
  assign rd_slot = (rd_sum >= DepthA) ? AW'(rd_sum - DepthA) : rd_sum[AW-1:0];
  assign wr_sum  = {1'b0, head_q} + {1'b0, count_q[AW-1:0]};
  assign wr_slot = (wr_sum >= DepthA) ? AW'(wr_sum - DepthA) : wr_sum[AW-1:0];

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    scan_d  = scan_q;
    if (cmd_i.enq) count_d = count_q + CW'(1);
    if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
      head_d  = (head_q == LastSlot) ? '0 : head_q + AW'(1);
    end
    if (cmd_i.capture) scan_d = '0;
    else if (cmd_i.scan_next) scan_d = scan_q + CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      scan_q      <= '0;
      cmd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      if (cmd_i.capture) cmd_q <= command_i;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      key_q <= key_in_i;
      pay_q <= payload_in_i;
      pos_q <= position_i;
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_key_q    <= cmd_i.res_data ? rd_key_q : '0;
      res_pay_q    <= cmd_i.res_data ? rd_pay_q : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_key_q    <= res_key_q;
      out_pay_q    <= res_pay_q;
      out_count_q  <= CountW'(count_q);
    end
  end

  // record memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.enq) begin
      key_mem[wr_slot] <= key_q;
      pay_mem[wr_slot] <= pay_q;
    end
    if (cmd_i.rd_en) begin
      rd_key_q <= key_mem[rd_slot];
      rd_pay_q <= pay_mem[rd_slot];
    end
  end

  assign sts_o.cmd       = cmd_q;
  assign sts_o.full      = (count_q == DepthC);
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.pos_bad   = (pos_ext >= CMPW'(count_q));
  assign sts_o.match     = (rd_key_q == key_q);
  // every held record has been compared
  assign sts_o.scan_done = (scan_q == count_q);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign key_out_o     = out_key_q;
  assign payload_out_o = out_pay_q;
  assign entry_count_o = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("record count beyond depth");

  a_enq_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.enq |=> count_q == $past(count_q) + CW'(1))
    else $error("enqueue did not advance the count");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd_en && cmd_i.rd_sel == srf_pkg::RD_SCAN) |-> scan_q < count_q)
    else $error("search read past the held records");

endmodule
